FILE: src/jpeg_huffman_table_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// jpeg huffman table decoder assertion macros
// shared assertion forms, clocked on aclk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef JPEG_HUFFMAN_TABLE_DECODER_TOP_DEFINES_SVH
`define JPEG_HUFFMAN_TABLE_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define JHTD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define JHTD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/jhtd_pkg.sv
// ----------------------------------------------------------------------------
// jhtd_pkg
// constants, codes and types of the canonical huffman table decoder
// ----------------------------------------------------------------------------
package jhtd_pkg;

    localparam int MAX_CODE_LEN = 16;
    localparam int MAX_SYMBOLS  = 256;

    localparam int CMD_W    = 3;
    localparam int LIDX_W   = 5;
    localparam int SYM_W    = 8;
    localparam int STATUS_W = 3;
    localparam int CLEN_W   = 5;

    localparam int LEN_AW   = $clog2(MAX_CODE_LEN);
    localparam int SYM_AW   = $clog2(MAX_SYMBOLS);
    localparam int LOADED_W = $clog2(MAX_SYMBOLS + 2);
    localparam int CODE_W   = MAX_CODE_LEN + 2;
    localparam int FC_W     = MAX_CODE_LEN + 1;
    localparam int FI_W     = SYM_AW + 1;
    localparam int TOTAL_W  = SYM_W + LEN_AW;

    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_CNT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_SYM = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FINISH   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DECODE   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_FEW   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 3'd5;

    // one row per code length
    typedef struct packed {
        logic [FC_W-1:0]  first_code;
        logic [FI_W-1:0]  first_index;
        logic [SYM_W-1:0] take;
    } tbl_entry_t;

endpackage

FILE: src/jpeg_huffman_table_decoder_top.sv
// latency: clear/load/no-op beats answer 2 cycles after accept, a decode beat 2 to 4
// cycles (table row read, then symbol memory read), finish 2 to 18 cycles (one length a cycle)
// throughput: one beat per 2 cycles at best; the input waits while the length walk or
// the two memory reads of a decode run, and one result may wait in the output register
// reset: aresetn synchronous active low; clears counts, fill count, flags and handshake
// state; symbol and table memories are not cleared (only rows written by a build are read)
// ----------------------------------------------------------------------------
// jpeg_huffman_table_decoder_top
// canonical huffman table build and bit-serial decode over two synchronous memories
// ----------------------------------------------------------------------------
`include "jpeg_huffman_table_decoder_top_defines.svh"

module jpeg_huffman_table_decoder_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [jhtd_pkg::CMD_W-1:0]      s_command,
    input  logic [jhtd_pkg::LIDX_W-1:0]     s_length_index,
    input  logic [jhtd_pkg::SYM_W-1:0]      s_count,
    input  logic [jhtd_pkg::SYM_W-1:0]      s_symbol_in,
    input  logic                            s_bit_req,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [jhtd_pkg::STATUS_W-1:0]   m_status,
    output logic                            m_symbol_valid,
    output logic [jhtd_pkg::SYM_W-1:0]      m_symbol,
    output logic [jhtd_pkg::CLEN_W-1:0]     m_cw_length
);
    import jhtd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_BUILD,
        S_DEC_CMP,
        S_DEC_SYM
    } state_t;

    state_t state_reg;

    // latched input beat
    logic [CMD_W-1:0]  cmd_reg;
    logic [LIDX_W-1:0] lidx_reg;
    logic [SYM_W-1:0]  cnt_reg;
    logic [SYM_W-1:0]  sym_in_reg;
    logic              bit_reg;

    // table state
    logic [SYM_W-1:0]    counts_reg [MAX_CODE_LEN];
    logic [LOADED_W-1:0] loaded_reg;
    logic [MAX_CODE_LEN-1:0] last_code_reg;
    logic [CLEN_W-1:0]   longest_reg;
    logic [MAX_CODE_LEN-1:0] partial_code_reg;
    logic [CLEN_W-1:0]   partial_length_reg;
    logic                table_ready_reg;
    logic                decode_error_reg;

    // length walk
    logic [LEN_AW-1:0]   walk_idx_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [FI_W-1:0]     index_reg;
    logic [LOADED_W-1:0] left_reg;
    logic [TOTAL_W-1:0]  total_reg;

    // output register
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic                m_symbol_valid_reg;
    logic [SYM_W-1:0]    m_symbol_reg;
    logic [CLEN_W-1:0]   m_cw_length_reg;

    // memories
    logic [SYM_W-1:0] sym_mem [MAX_SYMBOLS];
    tbl_entry_t       tbl_mem [MAX_CODE_LEN];
    logic [SYM_W-1:0] sym_rd_reg;
    tbl_entry_t       tbl_rd_reg;

    logic              sym_we;
    logic              sym_re;
    logic [SYM_AW-1:0] sym_ra;
    logic              tbl_we;
    logic              tbl_re;
    tbl_entry_t        tbl_wd;

    logic out_free;
    logic m_load;

    // walk step
    logic [SYM_W-1:0]    w_cnt;
    logic [SYM_W-1:0]    w_take;
    logic [CODE_W-1:0]   w_sum;
    logic [CODE_W-1:0]   w_limit;
    logic                w_overflow;
    logic                w_last;
    logic                w_go;
    logic [LOADED_W-1:0] w_left_after;
    logic [TOTAL_W-1:0]  w_total_after;
    logic [STATUS_W-1:0] w_final_status;

    // decode step
    logic [CLEN_W-1:0]       d_len;
    logic [MAX_CODE_LEN-1:0] d_v;
    logic [CODE_W-1:0]       d_end;
    logic                    d_hit;
    logic                    d_prefix_ok;
    logic [CLEN_W-1:0]       d_shift;
    logic                    d_lookup;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_symbol_valid = m_symbol_valid_reg;
    assign m_symbol       = m_symbol_reg;
    assign m_cw_length    = m_cw_length_reg;

    always_comb begin
        w_cnt   = counts_reg[walk_idx_reg];
        w_take  = ({1'b0, w_cnt} < left_reg) ? w_cnt : left_reg[SYM_W-1:0];
        w_sum   = code_reg + CODE_W'(w_take);
        w_limit = CODE_W'(1) << (CODE_W'(walk_idx_reg) + CODE_W'(1));
        w_overflow    = (w_sum > w_limit);
        w_last        = (walk_idx_reg == LEN_AW'(MAX_CODE_LEN - 1));
        w_go          = !(w_overflow || w_last) || out_free;
        w_left_after  = left_reg - LOADED_W'(w_take);
        w_total_after = total_reg + TOTAL_W'(w_cnt);
        if (w_left_after != '0) begin
            w_final_status = ST_TOO_MANY;
        end else if (w_total_after > TOTAL_W'(loaded_reg)) begin
            w_final_status = ST_TOO_FEW;
        end else begin
            w_final_status = ST_OK;
        end
        tbl_wd.first_code  = code_reg[FC_W-1:0];
        tbl_wd.first_index = index_reg;
        tbl_wd.take        = w_take;
    end

    always_comb begin
        d_len       = partial_length_reg + CLEN_W'(1);
        d_v         = {partial_code_reg[MAX_CODE_LEN-2:0], bit_reg};
        d_end       = CODE_W'(tbl_rd_reg.first_code) + CODE_W'(tbl_rd_reg.take);
        d_hit       = (FC_W'(d_v) >= tbl_rd_reg.first_code) && (CODE_W'(d_v) < d_end);
        d_shift     = longest_reg - d_len;
        d_prefix_ok = (d_len < longest_reg) && (d_v <= (last_code_reg >> d_shift));
        d_lookup    = table_ready_reg && !decode_error_reg && (d_len <= longest_reg);
        sym_ra      = tbl_rd_reg.first_index[SYM_AW-1:0]
                      + (d_v[SYM_AW-1:0] - tbl_rd_reg.first_code[SYM_AW-1:0]);
    end

    // a result beat is loaded into the output register
    always_comb begin
        case (state_reg)
            S_EXEC: begin
                m_load = out_free
                         && !((cmd_reg == CMD_FINISH) && (loaded_reg <= LOADED_W'(MAX_SYMBOLS)))
                         && !((cmd_reg == CMD_DECODE) && d_lookup);
            end
            S_BUILD: begin
                m_load = w_go && (w_overflow || w_last);
            end
            S_DEC_CMP: begin
                m_load = !d_hit && out_free;
            end
            S_DEC_SYM: begin
                m_load = out_free;
            end
            default: begin
                m_load = 1'b0;
            end
        endcase
    end

    assign sym_we = (state_reg == S_EXEC) && out_free && (cmd_reg == CMD_LOAD_SYM)
                    && (loaded_reg < LOADED_W'(MAX_SYMBOLS));
    assign sym_re = (state_reg == S_DEC_CMP) && d_hit;
    assign tbl_we = (state_reg == S_BUILD) && w_go && !w_overflow;
    assign tbl_re = (state_reg == S_EXEC) && out_free && (cmd_reg == CMD_DECODE) && d_lookup;

    always_ff @(posedge aclk) begin
        if (sym_we) begin
            sym_mem[loaded_reg[SYM_AW-1:0]] <= sym_in_reg;
        end
        if (sym_re) begin
            sym_rd_reg <= sym_mem[sym_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[walk_idx_reg] <= tbl_wd;
        end
        if (tbl_re) begin
            tbl_rd_reg <= tbl_mem[partial_length_reg[LEN_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_IDLE;
            m_valid_reg        <= 1'b0;
            loaded_reg         <= '0;
            last_code_reg      <= '0;
            longest_reg        <= '0;
            partial_code_reg   <= '0;
            partial_length_reg <= '0;
            table_ready_reg    <= 1'b0;
            decode_error_reg   <= 1'b0;
            for (int i = 0; i < MAX_CODE_LEN; i++) begin
                counts_reg[i] <= '0;
            end
        end else begin
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        cmd_reg    <= s_command;
                        lidx_reg   <= s_length_index;
                        cnt_reg    <= s_count;
                        sym_in_reg <= s_symbol_in;
                        bit_reg    <= s_bit_req;
                        state_reg  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        m_symbol_valid_reg <= 1'b0;
                        m_symbol_reg       <= '0;
                        case (cmd_reg)
                            CMD_CLEAR: begin
                                m_status_reg    <= ST_OK;
                                m_cw_length_reg <= '0;
                                state_reg       <= S_IDLE;
                                for (int i = 0; i < MAX_CODE_LEN; i++) begin
                                    counts_reg[i] <= '0;
                                end
                                loaded_reg         <= '0;
                                table_ready_reg    <= 1'b0;
                                decode_error_reg   <= 1'b0;
                                partial_code_reg   <= '0;
                                partial_length_reg <= '0;
                            end
                            CMD_LOAD_CNT: begin
                                m_status_reg    <= ST_OK;
                                m_cw_length_reg <= '0;
                                state_reg       <= S_IDLE;
                                if (lidx_reg != '0
                                    && lidx_reg <= LIDX_W'(MAX_CODE_LEN)) begin
                                    counts_reg[LEN_AW'(lidx_reg - LIDX_W'(1))] <= cnt_reg;
                                    table_ready_reg    <= 1'b0;
                                    partial_code_reg   <= '0;
                                    partial_length_reg <= '0;
                                end
                            end
                            CMD_LOAD_SYM: begin
                                m_status_reg    <= ST_OK;
                                m_cw_length_reg <= '0;
                                state_reg       <= S_IDLE;
                                if (loaded_reg <= LOADED_W'(MAX_SYMBOLS)) begin
                                    loaded_reg <= loaded_reg + LOADED_W'(1);
                                end
                                table_ready_reg    <= 1'b0;
                                partial_code_reg   <= '0;
                                partial_length_reg <= '0;
                            end
                            CMD_FINISH: begin
                                m_cw_length_reg    <= '0;
                                last_code_reg      <= '0;
                                longest_reg        <= '0;
                                table_ready_reg    <= 1'b0;
                                decode_error_reg   <= 1'b0;
                                partial_code_reg   <= '0;
                                partial_length_reg <= '0;
                                if (loaded_reg > LOADED_W'(MAX_SYMBOLS)) begin
                                    m_status_reg <= ST_TOO_MANY;
                                    state_reg    <= S_IDLE;
                                end else begin
                                    m_status_reg <= ST_OK;
                                    walk_idx_reg <= '0;
                                    code_reg     <= '0;
                                    index_reg    <= '0;
                                    left_reg     <= loaded_reg;
                                    total_reg    <= '0;
                                    state_reg    <= S_BUILD;
                                end
                            end
                            CMD_DECODE: begin
                                if (!table_ready_reg) begin
                                    m_status_reg       <= ST_NOT_READY;
                                    m_cw_length_reg    <= '0;
                                    state_reg          <= S_IDLE;
                                    decode_error_reg   <= 1'b1;
                                    partial_code_reg   <= '0;
                                    partial_length_reg <= '0;
                                end else if (decode_error_reg) begin
                                    m_status_reg    <= ST_INVALID;
                                    m_cw_length_reg <= '0;
                                    state_reg       <= S_IDLE;
                                end else if (!d_lookup) begin
                                    m_status_reg       <= ST_INVALID;
                                    m_cw_length_reg    <= d_len;
                                    state_reg          <= S_IDLE;
                                    decode_error_reg   <= 1'b1;
                                    partial_code_reg   <= '0;
                                    partial_length_reg <= '0;
                                end else begin
                                    m_status_reg    <= ST_OK;
                                    m_cw_length_reg <= '0;
                                    state_reg       <= S_DEC_CMP;
                                end
                            end
                            default: begin
                                m_status_reg    <= ST_OK;
                                m_cw_length_reg <= '0;
                                state_reg       <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_BUILD: begin
                    if (w_go) begin
                        if (w_overflow) begin
                            m_status_reg       <= ST_OVERFLOW;
                            m_symbol_valid_reg <= 1'b0;
                            m_symbol_reg       <= '0;
                            m_cw_length_reg    <= '0;
                            state_reg          <= S_IDLE;
                        end else begin
                            if (w_take != '0) begin
                                last_code_reg <= MAX_CODE_LEN'(w_sum - CODE_W'(1));
                                longest_reg   <= CLEN_W'(walk_idx_reg) + CLEN_W'(1);
                            end
                            code_reg     <= w_sum << 1;
                            index_reg    <= index_reg + FI_W'(w_take);
                            left_reg     <= w_left_after;
                            total_reg    <= w_total_after;
                            walk_idx_reg <= walk_idx_reg + LEN_AW'(1);
                            if (w_last) begin
                                m_status_reg       <= w_final_status;
                                m_symbol_valid_reg <= 1'b0;
                                m_symbol_reg       <= '0;
                                m_cw_length_reg    <= '0;
                                table_ready_reg    <= (w_final_status == ST_OK);
                                state_reg          <= S_IDLE;
                            end
                        end
                    end
                end
                S_DEC_CMP: begin
                    if (d_hit) begin
                        state_reg <= S_DEC_SYM;
                    end else if (out_free) begin
                        m_symbol_valid_reg <= 1'b0;
                        m_symbol_reg       <= '0;
                        m_cw_length_reg    <= d_len;
                        state_reg          <= S_IDLE;
                        if (d_prefix_ok) begin
                            m_status_reg       <= ST_OK;
                            partial_code_reg   <= d_v;
                            partial_length_reg <= d_len;
                        end else begin
                            m_status_reg       <= ST_INVALID;
                            decode_error_reg   <= 1'b1;
                            partial_code_reg   <= '0;
                            partial_length_reg <= '0;
                        end
                    end
                end
                S_DEC_SYM: begin
                    if (out_free) begin
                        m_status_reg       <= ST_OK;
                        m_symbol_valid_reg <= 1'b1;
                        m_symbol_reg       <= sym_rd_reg;
                        m_cw_length_reg    <= d_len;
                        partial_code_reg   <= '0;
                        partial_length_reg <= '0;
                        state_reg          <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `JHTD_ASSERT_IMP(a_sym_status_ok, m_valid_reg && m_symbol_valid_reg,
        m_status_reg == ST_OK, "symbol beat without ok status")
    `JHTD_ASSERT_IMP(a_partial_below_longest, partial_length_reg != '0,
        partial_length_reg < longest_reg, "gathered code not shorter than longest code")
    `JHTD_ASSERT_IMP(a_ready_from_build, $rose(table_ready_reg),
        $past(state_reg) == S_BUILD, "table ready set outside the length walk")
    `JHTD_ASSERT_IMP(a_loaded_bound, 1'b1,
        loaded_reg <= LOADED_W'(MAX_SYMBOLS + 1), "symbol fill count past its bound")

endmodule
